>>> rtl/core/qac_pkg.sv
// qac_pkg: shared constants, register codes and stage bundles of the attitude controller
// no dependencies; used by quadrotor_attitude_controller.sv
`timescale 1ns / 1ps
`default_nettype none

package qac_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ANGLE_GAIN_ROLL  = 3'd0,
    REG_ANGLE_GAIN_PITCH = 3'd1,
    REG_ANGLE_GAIN_YAW   = 3'd2,
    REG_RATE_GAIN_ROLL   = 3'd3,
    REG_RATE_GAIN_PITCH  = 3'd4,
    REG_RATE_GAIN_YAW    = 3'd5,
    REG_VEHICLE_MASS     = 3'd6
  } cfg_reg_t;

  // register reset values
  localparam logic [15:0] ANGLE_GAIN_RESET = 16'd256;
  localparam logic [31:0] RATE_GAIN_RESET  = 32'd0;
  localparam logic [15:0] MASS_RESET       = 16'd256;

  // angle constants in Q4.12
  localparam logic [11:0]        QUARTER_PI_Q12 = 12'd3217;
  localparam logic [11:0]        TILT_SAT_LIMIT = 12'd3218;
  localparam logic signed [16:0] PI_Q12         = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_Q12     = 17'sd25736;

  // divider geometry
  localparam int TILT_DEN_W        = 15;
  localparam int TILT_QUO_W        = 12;
  localparam int PQ_DEN_W          = 16;
  localparam int PQ_QUO_W          = 32;
  localparam int DIV_STEPS_DEFAULT = 4;

  // fields carried alongside the tilt divider and the following stages
  typedef struct packed {
    logic               sat_x;
    logic               sat_y;
    logic               neg_x;
    logic               neg_y;
    logic               thr_pos;
    logic [63:0]        rot_block;
    logic signed [15:0] rot_x_z;
    logic signed [15:0] rot_y_z;
    logic signed [15:0] rot_z_z;
    logic signed [31:0] cmd_r;
    logic signed [15:0] rate_p;
    logic signed [15:0] rate_q;
    logic signed [15:0] rate_r;
  } tilt_side_t;

  // fields carried alongside the p/q divider
  typedef struct packed {
    logic               thr_pos;
    logic               r22_zero;
    logic               neg_p;
    logic               neg_q;
    logic               ovf_p;
    logic               ovf_q;
    logic signed [31:0] cmd_r;
    logic signed [15:0] rate_p;
    logic signed [15:0] rate_q;
    logic signed [15:0] rate_r;
  } pq_side_t;

endpackage

`default_nettype wire

>>> rtl/core/qac_if.sv
// qac_sample_if and qac_result_if: valid/ready channels of the attitude controller
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface qac_sample_if;
  logic               valid;
  logic               ready;
  logic [63:0]        rotation_block;
  logic signed [15:0] rot_x_z;
  logic signed [15:0] rot_y_z;
  logic signed [15:0] rot_z_z;
  logic signed [15:0] accel_cmd_x;
  logic signed [15:0] accel_cmd_y;
  logic signed [15:0] thrust;
  logic signed [15:0] yaw;
  logic signed [15:0] yaw_target;
  logic signed [15:0] rate_p;
  logic signed [15:0] rate_q;
  logic signed [15:0] rate_r;

  modport source (
    output valid, rotation_block, rot_x_z, rot_y_z, rot_z_z, accel_cmd_x, accel_cmd_y,
           thrust, yaw, yaw_target, rate_p, rate_q, rate_r,
    input  ready
  );
  modport sink (
    input  valid, rotation_block, rot_x_z, rot_y_z, rot_z_z, accel_cmd_x, accel_cmd_y,
           thrust, yaw, yaw_target, rate_p, rate_q, rate_r,
    output ready
  );
endinterface

interface qac_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rate_cmd_p;
  logic signed [31:0] rate_cmd_q;
  logic signed [31:0] rate_cmd_r;
  logic signed [31:0] moment_x;
  logic signed [31:0] moment_y;
  logic signed [31:0] moment_z;
  logic               saturated;

  modport source (
    output valid, rate_cmd_p, rate_cmd_q, rate_cmd_r, moment_x, moment_y, moment_z,
           saturated,
    input  ready
  );
  modport sink (
    input  valid, rate_cmd_p, rate_cmd_q, rate_cmd_r, moment_x, moment_y, moment_z,
           saturated,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/core/qac_div_pipe.sv
// qac_div_pipe: pipelined restoring divider, several lanes over one shared divisor
// no package dependencies; STEPS quotient bits are resolved per register stage
`timescale 1ns / 1ps
`default_nettype none

module qac_div_pipe #(
  parameter int LANES  = 2,
  parameter int DEN_W  = 16,
  parameter int QUO_W  = 32,
  parameter int STEPS  = 4,
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [DEN_W-1:0]            den,
  input  logic [LANES-1:0][DEN_W-1:0] rem_init,
  input  logic [LANES-1:0][QUO_W-1:0] num_low,
  input  logic [SIDE_W-1:0]           side_in,
  output logic                        out_valid,
  output logic [LANES-1:0][QUO_W-1:0] quo,
  output logic [SIDE_W-1:0]           side_out
);

  localparam int STAGES = (QUO_W + STEPS - 1) / STEPS;

  typedef logic [LANES-1:0][DEN_W-1:0] rem_vec_t;
  typedef logic [LANES-1:0][QUO_W-1:0] wrk_vec_t;

  logic [STAGES-1:0] vld_in;
  logic [STAGES-1:0] vld_q;
  logic [DEN_W-1:0]  den_in [STAGES];
  logic [DEN_W-1:0]  den_q  [STAGES];
  rem_vec_t          rem_in [STAGES];
  rem_vec_t          rem_nx [STAGES];
  rem_vec_t          rem_q  [STAGES];
  wrk_vec_t          wrk_in [STAGES];
  wrk_vec_t          wrk_nx [STAGES];
  wrk_vec_t          wrk_q  [STAGES];
  logic [SIDE_W-1:0] side_s [STAGES];
  logic [SIDE_W-1:0] side_q [STAGES];

  // each stage reads the register of the stage before it
  always_comb begin
    vld_in[0] = in_valid;
    den_in[0] = den;
    rem_in[0] = rem_init;
    wrk_in[0] = num_low;
    side_s[0] = side_in;
    for (int s = 1; s < STAGES; s++) begin
      vld_in[s] = vld_q[s-1];
      den_in[s] = den_q[s-1];
      rem_in[s] = rem_q[s-1];
      wrk_in[s] = wrk_q[s-1];
      side_s[s] = side_q[s-1];
    end
  end

  // shift-subtract steps; dividend bits leave the top of wrk, quotient bits enter the bottom
  always_comb begin
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] wrk;
    for (int s = 0; s < STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rem = rem_in[s][l];
        wrk = wrk_in[s][l];
        for (int k = 0; k < STEPS; k++) begin
          if (s * STEPS + k < QUO_W) begin
            trial = {rem, wrk[QUO_W-1]};
            diff  = trial - {1'b0, den_in[s]};
            if (trial >= {1'b0, den_in[s]}) begin
              rem = diff[DEN_W-1:0];
              wrk = {wrk[QUO_W-2:0], 1'b1};
            end else begin
              rem = trial[DEN_W-1:0];
              wrk = {wrk[QUO_W-2:0], 1'b0};
            end
          end
        end
        rem_nx[s][l] = rem;
        wrk_nx[s][l] = wrk;
      end
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_in;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      den_q  <= den_in;
      rem_q  <= rem_nx;
      wrk_q  <= wrk_nx;
      side_q <= side_s;
    end
  end

  assign out_valid = vld_q[STAGES-1];
  assign quo       = wrk_q[STAGES-1];
  assign side_out  = side_q[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/qac_moment.sv
// qac_moment: three-stage moment path for one axis, gain times rate error, saturated
// no package dependencies; used three times by the top level
`timescale 1ns / 1ps
`default_nettype none

module qac_moment (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        gain,
  input  logic signed [31:0] cmd,
  input  logic signed [15:0] rate,
  output logic signed [31:0] value,
  output logic               sat
);

  logic signed [32:0] err;
  logic [32:0]        err_mag;
  logic               neg1;
  logic [32:0]        mag1;
  logic               neg2;
  logic [64:0]        prod2;
  logic [48:0]        scaled;
  logic               big;

  // rate error in Q16.16 and its magnitude
  always_comb begin
    err     = 33'(cmd) - 33'($signed({rate, 6'b0}));
    err_mag = err[32] ? 33'(-err) : 33'(err);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg1  <= err[32];
      mag1  <= err_mag;
      neg2  <= neg1;
      prod2 <= 65'(gain) * 65'(mag1);
    end
  end

  // drop the gain fraction, clamp the magnitude at 2^31, restore the sign
  always_comb begin
    scaled = prod2[64:16];
    big    = |scaled[48:31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg2) begin
        value <= big ? 32'sh8000_0000 : $signed(-scaled[31:0]);
        sat   <= 1'b0;
      end else begin
        value <= big ? 32'sh7fff_ffff : $signed(scaled[31:0]);
        sat   <= big;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/quadrotor_attitude_controller.sv
// depth: 10 + ceil(12/DIV_STEPS) + ceil(32/DIV_STEPS) register stages from the request input
// to the result output, with four quotient bits per divider stage by default
// throughput: one request per cycle; the pipeline stalls as a whole only while a result
// waits at the output; the two restoring dividers add the stages that depend on DIV_STEPS
// reset: synchronous; clears all stage valids and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none

module quadrotor_attitude_controller #(
  parameter int DIV_STEPS = qac_pkg::DIV_STEPS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [qac_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [qac_pkg::CFG_DATA_W-1:0]  wr_data,
  qac_sample_if.sink                      sample,
  qac_result_if.source                    result
);

  typedef struct packed {
    logic signed [31:0] cp;
    logic signed [31:0] cq;
    logic signed [31:0] cr;
    logic               flag;
  } cmd_set_t;

  // configuration registers
  logic [15:0] angle_gain_roll;
  logic [15:0] angle_gain_pitch;
  logic [15:0] angle_gain_yaw;
  logic [31:0] rate_gain_roll;
  logic [31:0] rate_gain_pitch;
  logic [31:0] rate_gain_yaw;
  logic [15:0] vehicle_mass;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_gain_roll  <= qac_pkg::ANGLE_GAIN_RESET;
      angle_gain_pitch <= qac_pkg::ANGLE_GAIN_RESET;
      angle_gain_yaw   <= qac_pkg::ANGLE_GAIN_RESET;
      rate_gain_roll   <= qac_pkg::RATE_GAIN_RESET;
      rate_gain_pitch  <= qac_pkg::RATE_GAIN_RESET;
      rate_gain_yaw    <= qac_pkg::RATE_GAIN_RESET;
      vehicle_mass     <= qac_pkg::MASS_RESET;
    end else if (wr_en) begin
      case (wr_index)
        qac_pkg::REG_ANGLE_GAIN_ROLL:  angle_gain_roll  <= wr_data[15:0];
        qac_pkg::REG_ANGLE_GAIN_PITCH: angle_gain_pitch <= wr_data[15:0];
        qac_pkg::REG_ANGLE_GAIN_YAW:   angle_gain_yaw   <= wr_data[15:0];
        qac_pkg::REG_RATE_GAIN_ROLL:   rate_gain_roll   <= wr_data;
        qac_pkg::REG_RATE_GAIN_PITCH:  rate_gain_pitch  <= wr_data;
        qac_pkg::REG_RATE_GAIN_YAW:    rate_gain_yaw    <= wr_data;
        qac_pkg::REG_VEHICLE_MASS:     vehicle_mass     <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the output holds an untaken result
  logic advance;
  logic vm3;

  assign advance      = !vm3 || result.ready;
  assign sample.ready = advance;

  // ---------------------------------------------------------------- stage 1
  logic [15:0]        ax_mag;
  logic [15:0]        ay_mag;
  logic signed [16:0] tgt;
  logic signed [16:0] yerr;

  always_comb begin
    ax_mag = sample.accel_cmd_x[15] ? 16'(-sample.accel_cmd_x) : sample.accel_cmd_x;
    ay_mag = sample.accel_cmd_y[15] ? 16'(-sample.accel_cmd_y) : sample.accel_cmd_y;
    // clamp yaw target, then wrap the error once each way
    tgt = {sample.yaw_target[15], sample.yaw_target};
    if (tgt > qac_pkg::TWO_PI_Q12) tgt = qac_pkg::TWO_PI_Q12;
    if (tgt < -qac_pkg::TWO_PI_Q12) tgt = -qac_pkg::TWO_PI_Q12;
    yerr = tgt - $signed({sample.yaw[15], sample.yaw});
    if (yerr > qac_pkg::PI_Q12) yerr = yerr - qac_pkg::TWO_PI_Q12;
    if (yerr < -qac_pkg::PI_Q12) yerr = yerr + qac_pkg::TWO_PI_Q12;
  end

  logic               v1;
  logic [31:0]        nx1;
  logic [31:0]        ny1;
  logic [26:0]        thr_k1;
  logic [14:0]        thr_mag1;
  logic               thr_pos1;
  logic               neg_x1;
  logic               neg_y1;
  logic [63:0]        rot1;
  logic signed [15:0] rxz1;
  logic signed [15:0] ryz1;
  logic signed [15:0] rzz1;
  logic signed [15:0] rp1;
  logic signed [15:0] rq1;
  logic signed [15:0] rr1;
  logic signed [16:0] yerr1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nx1      <= 32'(ax_mag) * 32'(vehicle_mass);
      ny1      <= 32'(ay_mag) * 32'(vehicle_mass);
      thr_k1   <= 27'(sample.thrust[14:0]) * 27'(qac_pkg::TILT_SAT_LIMIT);
      thr_mag1 <= sample.thrust[14:0];
      thr_pos1 <= !sample.thrust[15] && (sample.thrust != 16'sd0);
      neg_x1   <= !sample.accel_cmd_x[15];
      neg_y1   <= !sample.accel_cmd_y[15];
      rot1     <= sample.rotation_block;
      rxz1     <= sample.rot_x_z;
      ryz1     <= sample.rot_y_z;
      rzz1     <= sample.rot_z_z;
      rp1      <= sample.rate_p;
      rq1      <= sample.rate_q;
      rr1      <= sample.rate_r;
      yerr1    <= yerr;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // tilt clamps when the quotient reaches 3218; otherwise it fits 12 bits
  logic               sat_x;
  logic               sat_y;
  logic signed [33:0] yaw_prod;
  logic signed [33:0] yaw_cmd;

  always_comb begin
    sat_x    = {nx1, 4'b0} >= 36'(thr_k1);
    sat_y    = {ny1, 4'b0} >= 36'(thr_k1);
    yaw_prod = $signed({1'b0, angle_gain_yaw}) * yerr1;
    yaw_cmd  = (yaw_prod + (yaw_prod[33] ? 34'sd15 : 34'sd0)) >>> 4;
  end

  logic                                   v2;
  logic [1:0][qac_pkg::TILT_DEN_W-1:0]    tilt_rem2;
  logic [1:0][qac_pkg::TILT_QUO_W-1:0]    tilt_low2;
  logic [qac_pkg::TILT_DEN_W-1:0]         thr_mag2;
  qac_pkg::tilt_side_t                    side2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tilt_rem2[0]    <= nx1[22:8];
      tilt_rem2[1]    <= ny1[22:8];
      tilt_low2[0]    <= {nx1[7:0], 4'b0};
      tilt_low2[1]    <= {ny1[7:0], 4'b0};
      thr_mag2        <= thr_mag1;
      side2.sat_x     <= sat_x;
      side2.sat_y     <= sat_y;
      side2.neg_x     <= neg_x1;
      side2.neg_y     <= neg_y1;
      side2.thr_pos   <= thr_pos1;
      side2.rot_block <= rot1;
      side2.rot_x_z   <= rxz1;
      side2.rot_y_z   <= ryz1;
      side2.rot_z_z   <= rzz1;
      side2.cmd_r     <= $signed(yaw_cmd[31:0]);
      side2.rate_p    <= rp1;
      side2.rate_q    <= rq1;
      side2.rate_r    <= rr1;
    end
  end

  // ---------------------------------------------------------------- tilt divider
  logic                                        tdiv_valid;
  logic [1:0][qac_pkg::TILT_QUO_W-1:0]         tdiv_quo;
  logic [$bits(qac_pkg::tilt_side_t)-1:0]      tdiv_side_raw;
  qac_pkg::tilt_side_t                         tdiv_side;

  qac_div_pipe #(
    .LANES  (2),
    .DEN_W  (qac_pkg::TILT_DEN_W),
    .QUO_W  (qac_pkg::TILT_QUO_W),
    .STEPS  (DIV_STEPS),
    .SIDE_W ($bits(qac_pkg::tilt_side_t))
  ) u_tilt_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v2),
    .den       (thr_mag2),
    .rem_init  (tilt_rem2),
    .num_low   (tilt_low2),
    .side_in   (side2),
    .out_valid (tdiv_valid),
    .quo       (tdiv_quo),
    .side_out  (tdiv_side_raw)
  );

  assign tdiv_side = tdiv_side_raw;

  // ---------------------------------------------------------------- stage 3
  // tilt error against R02/R12, times the angle gain
  logic [11:0]        tmag_x;
  logic [11:0]        tmag_y;
  logic signed [13:0] tilt_x;
  logic signed [13:0] tilt_y;
  logic signed [16:0] terr_x;
  logic signed [16:0] terr_y;

  always_comb begin
    tmag_x = tdiv_side.sat_x ? qac_pkg::QUARTER_PI_Q12 : tdiv_quo[0];
    tmag_y = tdiv_side.sat_y ? qac_pkg::QUARTER_PI_Q12 : tdiv_quo[1];
    tilt_x = tdiv_side.neg_x ? -$signed({2'b0, tmag_x}) : $signed({2'b0, tmag_x});
    tilt_y = tdiv_side.neg_y ? -$signed({2'b0, tmag_y}) : $signed({2'b0, tmag_y});
    terr_x = $signed({tilt_x[13], tilt_x, 2'b0})
           - $signed({tdiv_side.rot_x_z[15], tdiv_side.rot_x_z});
    terr_y = $signed({tilt_y[13], tilt_y, 2'b0})
           - $signed({tdiv_side.rot_y_z[15], tdiv_side.rot_y_z});
  end

  logic                v3;
  logic signed [33:0]  er3;
  logic signed [33:0]  ep3;
  qac_pkg::tilt_side_t side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= tdiv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      er3   <= terr_x * $signed({1'b0, angle_gain_roll});
      ep3   <= terr_y * $signed({1'b0, angle_gain_pitch});
      side3 <= tdiv_side;
    end
  end

  // ---------------------------------------------------------------- stage 4
  // rotation block products, R00 in the lowest lane
  logic                v4;
  logic signed [49:0]  p10_4;
  logic signed [49:0]  p00_4;
  logic signed [49:0]  p11_4;
  logic signed [49:0]  p01_4;
  qac_pkg::tilt_side_t side4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      p10_4 <= $signed(side3.rot_block[47:32]) * er3;
      p00_4 <= $signed(side3.rot_block[15:0]) * ep3;
      p11_4 <= $signed(side3.rot_block[63:48]) * er3;
      p01_4 <= $signed(side3.rot_block[31:16]) * ep3;
      side4 <= side3;
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic                v5;
  logic signed [50:0]  np5;
  logic signed [50:0]  nq5;
  qac_pkg::tilt_side_t side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (advance) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      np5   <= 51'(p10_4) - 51'(p00_4);
      nq5   <= 51'(p11_4) - 51'(p01_4);
      side5 <= side4;
    end
  end

  // ---------------------------------------------------------------- stage 6
  // magnitudes over 64, then over |R22| in the divider; top bits decide overflow
  logic [50:0] mag_p;
  logic [50:0] mag_q;
  logic [15:0] rzz_mag;

  always_comb begin
    mag_p   = np5[50] ? 51'(-np5) : 51'(np5);
    mag_q   = nq5[50] ? 51'(-nq5) : 51'(nq5);
    rzz_mag = side5.rot_z_z[15] ? 16'(-side5.rot_z_z) : side5.rot_z_z;
  end

  logic                                v6;
  logic [1:0][qac_pkg::PQ_DEN_W-1:0]   pq_rem6;
  logic [1:0][qac_pkg::PQ_QUO_W-1:0]   pq_low6;
  logic [qac_pkg::PQ_DEN_W-1:0]        den6;
  qac_pkg::pq_side_t                   side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (advance) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pq_rem6[0]     <= {3'b0, mag_p[50:38]};
      pq_rem6[1]     <= {3'b0, mag_q[50:38]};
      pq_low6[0]     <= mag_p[37:6];
      pq_low6[1]     <= mag_q[37:6];
      den6           <= rzz_mag;
      side6.thr_pos  <= side5.thr_pos;
      side6.r22_zero <= (side5.rot_z_z == 16'sd0);
      side6.neg_p    <= np5[50] ^ side5.rot_z_z[15];
      side6.neg_q    <= nq5[50] ^ side5.rot_z_z[15];
      side6.ovf_p    <= {3'b0, mag_p[50:38]} >= rzz_mag;
      side6.ovf_q    <= {3'b0, mag_q[50:38]} >= rzz_mag;
      side6.cmd_r    <= side5.cmd_r;
      side6.rate_p   <= side5.rate_p;
      side6.rate_q   <= side5.rate_q;
      side6.rate_r   <= side5.rate_r;
    end
  end

  // ---------------------------------------------------------------- p/q divider
  logic                                    pdiv_valid;
  logic [1:0][qac_pkg::PQ_QUO_W-1:0]       pdiv_quo;
  logic [$bits(qac_pkg::pq_side_t)-1:0]    pdiv_side_raw;
  qac_pkg::pq_side_t                       pdiv_side;

  qac_div_pipe #(
    .LANES  (2),
    .DEN_W  (qac_pkg::PQ_DEN_W),
    .QUO_W  (qac_pkg::PQ_QUO_W),
    .STEPS  (DIV_STEPS),
    .SIDE_W ($bits(qac_pkg::pq_side_t))
  ) u_pq_div (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (v6),
    .den       (den6),
    .rem_init  (pq_rem6),
    .num_low   (pq_low6),
    .side_in   (side6),
    .out_valid (pdiv_valid),
    .quo       (pdiv_quo),
    .side_out  (pdiv_side_raw)
  );

  assign pdiv_side = pdiv_side_raw;

  // ---------------------------------------------------------------- stage 7
  // signed saturation of a magnitude quotient; top bit of the result is the flag
  function automatic logic [32:0] pq_result(input logic neg, input logic ovf,
                                            input logic [31:0] q);
    logic [32:0] res;
    if (neg) begin
      if (ovf || (q > 32'h8000_0000)) res = {1'b1, 32'h8000_0000};
      else                            res = {1'b0, 32'(-q)};
    end else begin
      if (ovf || q[31]) res = {1'b1, 32'h7fff_ffff};
      else              res = {1'b0, q};
    end
    return res;
  endfunction

  logic [32:0] res_p;
  logic [32:0] res_q;

  always_comb begin
    res_p = pq_result(pdiv_side.neg_p, pdiv_side.ovf_p, pdiv_quo[0]);
    res_q = pq_result(pdiv_side.neg_q, pdiv_side.ovf_q, pdiv_quo[1]);
  end

  logic               v7;
  logic               thr_pos7;
  cmd_set_t           cmd7;
  logic signed [15:0] rp7;
  logic signed [15:0] rq7;
  logic signed [15:0] rr7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (advance) begin
      v7 <= pdiv_valid;
    end
  end

  // no thrust or no R22 leaves p/q at zero
  always_ff @(posedge clk) begin
    if (advance) begin
      thr_pos7 <= pdiv_side.thr_pos;
      cmd7.cr  <= pdiv_side.cmd_r;
      rp7      <= pdiv_side.rate_p;
      rq7      <= pdiv_side.rate_q;
      rr7      <= pdiv_side.rate_r;
      if (!pdiv_side.thr_pos || pdiv_side.r22_zero) begin
        cmd7.cp   <= '0;
        cmd7.cq   <= '0;
        cmd7.flag <= pdiv_side.thr_pos;
      end else begin
        cmd7.cp   <= $signed(res_p[31:0]);
        cmd7.cq   <= $signed(res_q[31:0]);
        cmd7.flag <= res_p[32] | res_q[32];
      end
    end
  end

  // ---------------------------------------------------------------- moment stages
  logic               vm1;
  logic               vm2;
  cmd_set_t           cmd_m1;
  cmd_set_t           cmd_m2;
  cmd_set_t           cmd_m3;
  logic signed [31:0] mx;
  logic signed [31:0] my;
  logic signed [31:0] mz;
  logic               mx_sat;
  logic               my_sat;
  logic               mz_sat;

  qac_moment u_moment_x (
    .clk   (clk),
    .en    (advance),
    .gain  (rate_gain_roll),
    .cmd   (cmd7.cp),
    .rate  (rp7),
    .value (mx),
    .sat   (mx_sat)
  );

  qac_moment u_moment_y (
    .clk   (clk),
    .en    (advance),
    .gain  (rate_gain_pitch),
    .cmd   (cmd7.cq),
    .rate  (rq7),
    .value (my),
    .sat   (my_sat)
  );

  qac_moment u_moment_z (
    .clk   (clk),
    .en    (advance),
    .gain  (rate_gain_yaw),
    .cmd   (cmd7.cr),
    .rate  (rr7),
    .value (mz),
    .sat   (mz_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
      vm2 <= 1'b0;
      vm3 <= 1'b0;
    end else if (advance) begin
      vm1 <= v7;
      vm2 <= vm1;
      vm3 <= vm2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_m1 <= cmd7;
      cmd_m2 <= cmd_m1;
      cmd_m3 <= cmd_m2;
    end
  end

  // ---------------------------------------------------------------- output
  assign result.valid      = vm3;
  assign result.rate_cmd_p = cmd_m3.cp;
  assign result.rate_cmd_q = cmd_m3.cq;
  assign result.rate_cmd_r = cmd_m3.cr;
  assign result.moment_x   = mx;
  assign result.moment_y   = my;
  assign result.moment_z   = mz;
  assign result.saturated  = cmd_m3.flag | mx_sat | my_sat | mz_sat;

  // ---------------------------------------------------------------- assertions
  a_take_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> v1)
    else $error("accepted request did not enter the first stage");

  a_no_thrust_zero_pq: assert property (@(posedge clk) disable iff (rst)
    v7 && !thr_pos7 |-> cmd7.cp == 32'sd0 && cmd7.cq == 32'sd0 && !cmd7.flag)
    else $error("p/q commands nonzero or flagged without positive thrust");

  a_moment_sat_flag: assert property (@(posedge clk) disable iff (rst)
    result.valid && mx_sat |-> result.saturated && result.moment_x == 32'sh7fff_ffff)
    else $error("roll moment saturation not reflected at the output");

endmodule

`default_nettype wire
